/* sv/cbba_pkg.sv */
// Package for the contiguous block bitmap allocator.
// Holds the status and operation codes, the controller state type and the
// command and status groups between controller and datapath. No dependencies.
package cbba_pkg;

  localparam int NUM_BLOCKS_DEF = 192;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic check;
    logic scan;
    logic wr_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic bad;
    logic empty;
    logic hit;
    logic miss;
    logic wr_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/contiguous_block_bitmap_allocator.sv */
// First-fit contiguous block allocator over a pool of NUM_BLOCKS blocks, one
// used bit per block held in a RAM. After reset the block clears the map, one
// entry a cycle, before it takes its first request. A request is handled one
// at a time. An allocate scans the map bits up to the end of the first fitting
// run, at most NUM_BLOCKS, and then writes the run back; a free writes its
// range back directly, and a rejected request writes nothing. The map RAM has
// a single read and a single write port, one bit per cycle each.
// The result sits in an output register, so a new request is taken while it
// waits for its transfer.
module contiguous_block_bitmap_allocator #(
  parameter int NUM_BLOCKS = cbba_pkg::NUM_BLOCKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] block_count_i,
  input  logic [7:0] start_block_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] run_start_o,
  output logic [7:0] granted_count_o
);
  import cbba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cbba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbba_dp #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .block_count_i   (block_count_i),
    .start_block_i   (start_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .run_start_o     (run_start_o),
    .granted_count_o (granted_count_o)
  );

endmodule

/* sv/cbba_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the block used map. No dependencies.
module cbba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 192
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/cbba_ctrl.sv */
// Controller state machine of the allocator.
// Depends on cbba_pkg for the state, command and status types.
module cbba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cbba_pkg::sts_t sts_i,
  output cbba_pkg::cmd_t cmd_o
);
  import cbba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.bad) begin
          state_d = S_DONE;
        end else if (sts_i.is_alloc) begin
          state_d = S_SCAN;
        end else if (sts_i.empty) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          state_d = S_WRITE;
        end else if (sts_i.miss) begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        if (sts_i.wr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: cmd_o.check   = 1'b1;
      S_SCAN:  cmd_o.scan    = 1'b1;
      S_WRITE: cmd_o.wr_step = 1'b1;
      S_DONE:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/cbba_dp.sv */
// Datapath of the allocator: request registers, scan and write pointers,
// run counter, result and output registers, and the used map RAM.
// Depends on cbba_pkg and cbba_ram.
module cbba_dp #(
  parameter int NUM_BLOCKS = cbba_pkg::NUM_BLOCKS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbba_pkg::cmd_t cmd_i,
  output cbba_pkg::sts_t sts_o,
  input  logic           operation_i,
  input  logic [7:0]     block_count_i,
  input  logic [7:0]     start_block_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic [7:0]     run_start_o,
  output logic [7:0]     granted_count_o
);
  import cbba_pkg::*;

  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam logic [SUM_W-1:0] NS   = SUM_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] NC   = CNT_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] LASTC = CNT_W'(NUM_BLOCKS - 1);
  localparam logic [IDX_W-1:0] LASTI = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [7:0]       NB   = 8'(NUM_BLOCKS);

  logic             op_q;
  logic [7:0]       cnt_q, start_q;
  logic [CNT_W-1:0] addr_q, end_q, run_q;
  logic [IDX_W-1:0] chk_addr_q;
  logic             chk_vld_q;
  logic             wval_q;
  status_e          res_status_q;
  logic [7:0]       res_first_q, res_count_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [7:0]       out_first_q, out_count_q;

  logic [SUM_W-1:0] cnt_s, start_s, free_end_s, first_s;
  logic [CNT_W-1:0] run_nxt;
  logic             alloc_bad, free_bad, hit, miss, rd_data;
  logic             ram_we;

  assign cnt_s      = SUM_W'(cnt_q);
  assign start_s    = SUM_W'(start_q);
  assign free_end_s = start_s + cnt_s;
  assign alloc_bad  = (cnt_q == 8'd0) || (cnt_s > NS);
  assign free_bad   = free_end_s > NS;

  // The run counter never passes the number of blocks seen so far.
  assign run_nxt = rd_data ? '0 : CNT_W'(run_q + 1'b1);
  assign hit     = chk_vld_q && (SUM_W'(run_nxt) == cnt_s);
  assign miss    = chk_vld_q && !hit && (chk_addr_q == LASTI);
  assign first_s = SUM_W'(chk_addr_q) + SUM_W'(1) - cnt_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      cnt_q   <= block_count_i;
      start_q <= start_block_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr || cmd_i.wr_step) begin
        addr_q <= CNT_W'(addr_q + 1'b1);
      end else if (cmd_i.check) begin
        addr_q <= (op_q == OP_ALLOC) ? '0 : CNT_W'(start_s);
      end else if (cmd_i.scan) begin
        if (hit) begin
          addr_q <= CNT_W'(first_s);
        end else if (addr_q < NC) begin
          addr_q <= CNT_W'(addr_q + 1'b1);
        end
      end
      if (cmd_i.scan) begin
        chk_vld_q <= (addr_q < NC) && !hit;
      end else begin
        chk_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      run_q  <= '0;
      end_q  <= CNT_W'(free_end_s);
      wval_q <= 1'b0;
      if (op_q == OP_ALLOC) begin
        res_status_q <= ST_BAD_SIZE;
        res_first_q  <= NB;
        res_count_q  <= 8'd0;
      end else if (free_bad) begin
        res_status_q <= ST_BAD_RANGE;
        res_first_q  <= NB;
        res_count_q  <= 8'd0;
      end else begin
        res_status_q <= ST_OK;
        res_first_q  <= start_q;
        res_count_q  <= cnt_q;
      end
    end else if (cmd_i.scan) begin
      chk_addr_q <= addr_q[IDX_W-1:0];
      if (chk_vld_q) begin
        run_q <= run_nxt;
      end
      if (hit) begin
        end_q        <= CNT_W'(first_s + cnt_s);
        wval_q       <= 1'b1;
        res_status_q <= ST_OK;
        res_first_q  <= 8'(first_s);
        res_count_q  <= cnt_q;
      end else if (miss) begin
        res_status_q <= ST_NO_SPACE;
        res_first_q  <= NB;
        res_count_q  <= 8'd0;
      end
    end
  end

  // Output register: the next request may be worked on while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_count_q  <= res_count_q;
    end
  end

  assign ram_we = cmd_i.clr_wr || cmd_i.wr_step;

  cbba_ram #(
    .WIDTH(1),
    .DEPTH(NUM_BLOCKS)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (addr_q[IDX_W-1:0]),
    .wr_data_i (cmd_i.wr_step & wval_q),
    .rd_en_i   (cmd_i.scan),
    .rd_addr_i (addr_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = (addr_q == LASTC);
    sts_o.is_alloc = (op_q == OP_ALLOC);
    sts_o.bad      = (op_q == OP_ALLOC) ? alloc_bad : free_bad;
    sts_o.empty    = (cnt_q == 8'd0);
    sts_o.hit      = hit;
    sts_o.miss     = miss;
    sts_o.wr_last  = (CNT_W'(addr_q + 1'b1) == end_q);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign run_start_o     = out_first_q;
  assign granted_count_o = out_count_q;

endmodule

/* sv/cbba_checker.sv */
// Port-level checker for the allocator, attached to the top level by bind.
// Depends on cbba_pkg for the status codes.
module cbba_checker #(
  parameter int NUM_BLOCKS = cbba_pkg::NUM_BLOCKS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] run_start_o,
  input logic [7:0] granted_count_o
);
  import cbba_pkg::*;

  localparam logic [7:0] NB = 8'(NUM_BLOCKS);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(run_start_o) && $stable(granted_count_o))
    else $error("result changed while stalled");

  // Requests are processed one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // A failed request grants nothing.
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> granted_count_o == 8'd0)
    else $error("failure with nonzero count");

  // A failed request reports the pool size as its first block.
  a_fail_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> run_start_o == NB)
    else $error("failure with wrong first block");

endmodule

bind contiguous_block_bitmap_allocator cbba_checker #(
  .NUM_BLOCKS(NUM_BLOCKS)
) u_cbba_checker (.*);
